[hdl/lpc_pkg.sv]
// Shared types and constants for the line position centroid block.
// Used by every module under hdl/; depends on nothing else.
`timescale 1ns / 1ps

package lpc_pkg;

  // Sensor array geometry (the array is always eight sensors wide).
  localparam int NUM_SENSORS     = 8;
  localparam int IDX_W           = $clog2(NUM_SENSORS);
  localparam int SAMPLE_BITS_DEF = 10;

  // Configuration register widths and reset values.
  localparam int CFG_ADDR_W   = 2;
  localparam int EDGE_THR_W   = 10;
  localparam int CONTRAST_W   = 10;
  localparam int SIG_SUM_W    = 13;
  localparam int CFG_DATA_W   = 13;

  localparam logic [EDGE_THR_W-1:0] EDGE_THR_RST   = 10'd100;
  localparam logic [CONTRAST_W-1:0] CONTRAST_RST   = 10'd200;
  localparam logic [SIG_SUM_W-1:0]  SIG_SUM_RST    = 13'd100;

  // Result fields.
  localparam int POS_W  = 8;
  localparam int SRC_W  = 2;
  localparam int QUOT_W = 8;

  // Full scale is 2^SCALE_SH - 1 = 127, so 127*x is (x << SCALE_SH) - x.
  localparam int SCALE_SH = 7;
  localparam logic signed [POS_W-1:0] POS_LEFT  = -8'sd127;
  localparam logic signed [POS_W-1:0] POS_RIGHT = 8'sd127;
  localparam logic [QUOT_W-1:0]       QUOT_MAX  = 8'd127;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_EDGE_THRESHOLD = 2'd0,
    CFG_MIN_CONTRAST   = 2'd1,
    CFG_MIN_SIGNAL_SUM = 2'd2
  } cfg_idx_e;

  typedef enum logic [SRC_W-1:0] {
    SRC_CENTROID     = 2'd0,
    SRC_EDGE         = 2'd1,
    SRC_LOW_CONTRAST = 2'd2,
    SRC_LOW_SIGNAL   = 2'd3
  } src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_LOAD,
    ST_DIV,
    ST_SIGN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } frame_cmd_t;

  typedef struct packed {
    logic low_contrast;
    logic edge_left;
    logic edge_right;
    logic low_signal;
    logic w_neg;
  } frame_flags_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_cmd_t;

endpackage

[hdl/lpc_frame.sv]
// Frame unit: rotating sample register that feeds one sensor per step cycle into
// the min/max, sum and weighted-sum accumulators. Depends on lpc_pkg.
`timescale 1ns / 1ps

module lpc_frame
  import lpc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  frame_cmd_t                        cmd_i,
  input  logic [NUM_SENSORS*SAMPLE_BITS-1:0] samples_i,
  input  logic [EDGE_THR_W-1:0]             edge_thr_i,
  input  logic [CONTRAST_W-1:0]             min_contrast_i,
  input  logic [SIG_SUM_W-1:0]              min_sig_sum_i,
  output frame_flags_t                      flags_o,
  output logic [SAMPLE_BITS+4:0]            w_abs_o,
  output logic [SAMPLE_BITS+2:0]            sum_o
);

  localparam int SUM_W = SAMPLE_BITS + 3;
  localparam int WB    = SAMPLE_BITS + 6;
  localparam int CW    = SAMPLE_BITS + 6;

  logic [SAMPLE_BITS-1:0] sh_q [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] sh_d [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [SUM_W-1:0]       sum_q, sum_d, sumn_q;
  logic signed [WB-1:0]   w_q, w_d;
  logic [WB-2:0]          wabs_q;
  logic                   wneg_q;

  logic [SAMPLE_BITS-1:0] x;
  logic signed [IDX_W+1:0] wt;
  logic signed [WB-1:0]   xs, wts, prod;
  logic [SAMPLE_BITS-1:0] span, diff_l, diff_r;

  assign x    = sh_q[0];
  // Weight of sensor i is 2i - 7.
  assign wt   = signed'({1'b0, cmd_i.idx, 1'b0}) - signed'((IDX_W+2)'(NUM_SENSORS - 1));
  assign xs   = signed'(WB'(x));
  assign wts  = WB'(wt);
  assign prod = xs * wts;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sh_d[i] = sh_q[i];
    end
    hi_d  = hi_q;
    lo_d  = lo_q;
    sum_d = sum_q;
    w_d   = w_q;
    if (cmd_i.load) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        sh_d[i] = samples_i[i*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end else if (cmd_i.step) begin
      // Rotate by one sensor; after a full pass the original order is back.
      for (int i = 0; i < NUM_SENSORS - 1; i++) begin
        sh_d[i] = sh_q[i+1];
      end
      sh_d[NUM_SENSORS-1] = sh_q[0];
      if (cmd_i.idx == '0) begin
        hi_d  = x;
        lo_d  = x;
        sum_d = SUM_W'(x);
        w_d   = prod;
      end else begin
        hi_d  = (x > hi_q) ? x : hi_q;
        lo_d  = (x < lo_q) ? x : lo_q;
        sum_d = sum_q + SUM_W'(x);
        w_d   = w_q + prod;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      sh_q[i] <= sh_d[i];
    end
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    sum_q <= sum_d;
    w_q   <= w_d;
    // The weights sum to zero, so subtracting the minimum leaves the
    // weighted sum unchanged and only the plain sum needs correcting.
    if (cmd_i.finish) begin
      sumn_q <= sum_q - (SUM_W'(lo_q) << IDX_W);
      wneg_q <= w_q[WB-1];
      wabs_q <= w_q[WB-1] ? (WB-1)'(-w_q) : w_q[WB-2:0];
    end
  end

  assign span   = hi_q - lo_q;
  assign diff_l = sh_q[0] - sh_q[1];
  assign diff_r = sh_q[NUM_SENSORS-1] - sh_q[NUM_SENSORS-2];

  always_comb begin
    flags_o.low_contrast = CW'(span) < CW'(min_contrast_i);
    flags_o.edge_left    = (sh_q[0] == hi_q) && (CW'(diff_l) >= CW'(edge_thr_i));
    flags_o.edge_right   = (sh_q[NUM_SENSORS-1] == hi_q) &&
                           (CW'(diff_r) >= CW'(edge_thr_i));
    flags_o.low_signal   = (CW'(sumn_q) < CW'(min_sig_sum_i)) || (sumn_q == '0);
    flags_o.w_neg        = wneg_q;
  end

  assign w_abs_o = wabs_q;
  assign sum_o   = sumn_q;

endmodule

[hdl/lpc_div.sv]
// Bit-serial restoring divider: one quotient bit per step cycle, shifting the
// scaled divisor right. Computes 127*|W| / (7*sum). Depends on lpc_pkg.
`timescale 1ns / 1ps

module lpc_div
  import lpc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  div_cmd_t                cmd_i,
  input  logic [SAMPLE_BITS+4:0]  w_abs_i,
  input  logic [SAMPLE_BITS+2:0]  sum_i,
  output logic [QUOT_W-1:0]       quot_o
);

  localparam int NW = SAMPLE_BITS + 5 + SCALE_SH;
  localparam int SW = SAMPLE_BITS + 3 + IDX_W;
  localparam int DW = SW + QUOT_W - 1;

  logic [NW-1:0]     rem_q, num;
  logic [DW-1:0]     dsh_q;
  logic [SW-1:0]     den;
  logic [QUOT_W-1:0] quot_q;
  logic              ge;

  // 127*x as (x << 7) - x and 7*s as (s << 3) - s.
  assign num = (NW'(w_abs_i) << SCALE_SH) - NW'(w_abs_i);
  assign den = (SW'(sum_i) << IDX_W) - SW'(sum_i);
  assign ge  = DW'(rem_q) >= dsh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q  <= num;
      dsh_q  <= DW'(den) << (QUOT_W - 1);
      quot_q <= '0;
    end else if (cmd_i.step) begin
      if (ge) begin
        rem_q <= rem_q - NW'(dsh_q);
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign quot_o = quot_q;

endmodule

[hdl/lpc_ctrl.sv]
// Sequencer: steps the frame unit and divider, picks the result source,
// keeps the last position and drives the output register. Depends on lpc_pkg.
`timescale 1ns / 1ps

module lpc_ctrl
  import lpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output frame_cmd_t        fcmd_o,
  input  frame_flags_t      flags_i,
  output div_cmd_t          dcmd_o,
  input  logic [QUOT_W-1:0] quot_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [POS_W-1:0]  m_pos_o,
  output logic [SRC_W-1:0]  m_src_o
);

  state_e state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic cnt_clr, cnt_inc, cnt_last;
  logic res_ld, last_ld, out_ld;
  logic signed [POS_W-1:0] res_pos, res_pos_q, last_q, out_pos_q, cent_pos;
  src_e res_src, res_src_q, out_src_q;
  logic out_valid_q;
  logic [QUOT_W-1:0] quot_c;

  assign cnt_last = (cnt_q == IDX_W'(NUM_SENSORS - 1));

  assign quot_c   = (quot_i > QUOT_MAX) ? QUOT_MAX : quot_i;
  assign cent_pos = flags_i.w_neg ? -signed'(quot_c) : signed'(quot_c);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_valid_i) state_d = ST_SCAN;
      ST_SCAN:  if (cnt_last) state_d = ST_CHECK;
      ST_CHECK: begin
        if (flags_i.low_contrast || flags_i.edge_left || flags_i.edge_right) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD:  state_d = flags_i.low_signal ? ST_OUT : ST_DIV;
      ST_DIV:   if (cnt_q == IDX_W'(QUOT_W - 1)) state_d = ST_SIGN;
      ST_SIGN:  state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || m_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_ready_o = 1'b0;
    fcmd_o    = '0;
    dcmd_o    = '0;
    cnt_clr   = 1'b0;
    cnt_inc   = 1'b0;
    res_ld    = 1'b0;
    last_ld   = 1'b0;
    out_ld    = 1'b0;
    res_pos   = last_q;
    res_src   = SRC_CENTROID;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o   = 1'b1;
        fcmd_o.load = s_valid_i;
        cnt_clr     = 1'b1;
      end
      ST_SCAN: begin
        fcmd_o.step = 1'b1;
        fcmd_o.idx  = cnt_q;
        cnt_inc     = 1'b1;
      end
      ST_CHECK: begin
        fcmd_o.finish = 1'b1;
        priority if (flags_i.low_contrast) begin
          res_ld  = 1'b1;
          res_src = SRC_LOW_CONTRAST;
        end else if (flags_i.edge_left) begin
          res_ld  = 1'b1;
          last_ld = 1'b1;
          res_pos = POS_LEFT;
          res_src = SRC_EDGE;
        end else if (flags_i.edge_right) begin
          res_ld  = 1'b1;
          last_ld = 1'b1;
          res_pos = POS_RIGHT;
          res_src = SRC_EDGE;
        end else begin
          res_ld  = 1'b0;
        end
      end
      ST_LOAD: begin
        if (flags_i.low_signal) begin
          res_ld  = 1'b1;
          res_src = SRC_LOW_SIGNAL;
        end else begin
          dcmd_o.start = 1'b1;
          cnt_clr      = 1'b1;
        end
      end
      ST_DIV: begin
        dcmd_o.step = 1'b1;
        cnt_inc     = 1'b1;
      end
      ST_SIGN: begin
        res_ld  = 1'b1;
        last_ld = 1'b1;
        res_pos = cent_pos;
      end
      ST_OUT: begin
        out_ld = !out_valid_q || m_ready_i;
      end
      default: begin
        cnt_clr = 1'b1;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cnt_clr) begin
      cnt_d = '0;
    end else if (cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (last_ld) begin
        last_q <= res_pos;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld) begin
      res_pos_q <= res_pos;
      res_src_q <= res_src;
    end
    if (out_ld) begin
      out_pos_q <= res_pos_q;
      out_src_q <= res_src_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_pos_o   = out_pos_q;
  assign m_src_o   = out_src_q;

endmodule

[hdl/line_position_centroid.sv]
// An accepted beat is scanned sensor by sensor, then checked; a low contrast
// or edge result goes straight to the output register, a low signal result
// after the load state, and a centroid result after the divider (one quotient
// bit per step) and the sign state. A new beat is taken only back in idle, and
// a full output register lets the next frame start while a result waits.
// Reset returns the sequencer, last position and config registers to defaults.
`timescale 1ns / 1ps

module line_position_centroid
  import lpc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]              cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]              cfg_wdata_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample_0 .. sample_7, SAMPLE_BITS each, sample_0 in the lowest bits
  input  logic [NUM_SENSORS*SAMPLE_BITS-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // position (8 bits, signed)
  output logic [POS_W-1:0]                   m_axis_tdata,
  // source (2 bits)
  output logic [SRC_W-1:0]                   m_axis_tuser
);

  logic [EDGE_THR_W-1:0] edge_thr_q;
  logic [CONTRAST_W-1:0] min_contrast_q;
  logic [SIG_SUM_W-1:0]  min_sig_sum_q;

  frame_cmd_t   fcmd;
  frame_flags_t flags;
  div_cmd_t     dcmd;
  logic [SAMPLE_BITS+4:0] w_abs;
  logic [SAMPLE_BITS+2:0] sum_n;
  logic [QUOT_W-1:0]      quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_thr_q     <= EDGE_THR_RST;
      min_contrast_q <= CONTRAST_RST;
      min_sig_sum_q  <= SIG_SUM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_EDGE_THRESHOLD: edge_thr_q     <= cfg_wdata_i[EDGE_THR_W-1:0];
        CFG_MIN_CONTRAST:   min_contrast_q <= cfg_wdata_i[CONTRAST_W-1:0];
        CFG_MIN_SIGNAL_SUM: min_sig_sum_q  <= cfg_wdata_i[SIG_SUM_W-1:0];
        default: ;
      endcase
    end
  end

  lpc_frame #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_frame (
    .clk_i          (clk_i),
    .cmd_i          (fcmd),
    .samples_i      (s_axis_tdata),
    .edge_thr_i     (edge_thr_q),
    .min_contrast_i (min_contrast_q),
    .min_sig_sum_i  (min_sig_sum_q),
    .flags_o        (flags),
    .w_abs_o        (w_abs),
    .sum_o          (sum_n)
  );

  lpc_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .cmd_i   (dcmd),
    .w_abs_i (w_abs),
    .sum_i   (sum_n),
    .quot_o  (quot)
  );

  lpc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .fcmd_o    (fcmd),
    .flags_i   (flags),
    .dcmd_o    (dcmd),
    .quot_i    (quot),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_pos_o   (m_axis_tdata),
    .m_src_o   (m_axis_tuser)
  );

endmodule

[hdl/lpc_checker.sv]
// Port-level checks for line_position_centroid, attached by the bind below.
// Depends on lpc_pkg and the top level's ports.
`timescale 1ns / 1ps

module lpc_checker
  import lpc_pkg::*;
(
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [POS_W-1:0]                   m_axis_tdata,
  input logic [SRC_W-1:0]                   m_axis_tuser
);

  // A result beat stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Only one frame is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second frame accepted while one is in work");

  // The position never reaches the most negative code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != 8'h80)
    else $error("position out of range");

  // An edge result is always full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == SRC_EDGE) |->
      (m_axis_tdata == POS_LEFT) || (m_axis_tdata == POS_RIGHT))
    else $error("edge result is not full scale");

endmodule

bind line_position_centroid lpc_checker u_lpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
